// ===== src/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared widths, reset values, codes and the level band table.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int unsigned RING_DEPTH   = 30;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned PROD_W       = 22;
  localparam int unsigned VOLT_W       = 19;
  localparam int unsigned LEVEL_W      = 7;
  localparam int unsigned SRC_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned WARM_W       = 8;
  localparam int unsigned OFFSET_W     = 8;
  localparam int unsigned SCALE_W      = 10;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 32;
  localparam int unsigned VOLT_DIVISOR = 10;
  localparam int unsigned NUM_BANDS    = 10;

  localparam logic [OFFSET_W-1:0] MEDIAN_OFFSET_RESET = 8'd10;
  localparam logic [OFFSET_W-1:0] EXTRA_OFFSET_RESET  = 8'd10;
  localparam logic [SAMPLE_W-1:0] CLAMP_LOW_RESET     = 12'd250;
  localparam logic [SAMPLE_W-1:0] CLAMP_HIGH_RESET    = 12'd450;
  localparam logic [SCALE_W-1:0]  SCALE_RESET         = 10'd100;
  localparam logic [WARM_W-1:0]   WARMUP_RESET        = 8'd30;
  localparam logic [WARM_W-1:0]   REWARM_RESET        = 8'd3;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL          = 7'd100;

  typedef enum logic [SRC_W-1:0] {
    SRC_BATTERY = 2'd0,
    SRC_USB     = 2'd1,
    SRC_AC      = 2'd2
  } src_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_IDLE     = 2'd0,
    STAT_CHARGING = 2'd1,
    STAT_FULL     = 2'd2
  } charge_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEDIAN_OFFSET = 3'd0,
    CFG_EXTRA_OFFSET  = 3'd1,
    CFG_CLAMP_LOW     = 3'd2,
    CFG_CLAMP_HIGH    = 3'd3,
    CFG_VOLT_SCALE    = 3'd4,
    CFG_WARMUP_ITEMS  = 3'd5,
    CFG_REWARM_ITEMS  = 3'd6
  } cfg_index_e;

  localparam logic [SAMPLE_W-1:0] BAND_FLOOR [NUM_BANDS] = '{
    12'd431, 12'd413, 12'd411, 12'd408, 12'd404,
    12'd398, 12'd390, 12'd383, 12'd328, 12'd308
  };

  localparam logic [LEVEL_W-1:0] BAND_PCT [NUM_BANDS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
  };

  // The highest band whose floor is reached wins; below every floor gives zero.
  function automatic logic [LEVEL_W-1:0] band_level(input logic [SAMPLE_W-1:0] v);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int i = NUM_BANDS - 1; i >= 0; i--) begin
      if (v >= BAND_FLOOR[i]) begin
        lvl = BAND_PCT[i];
      end
    end
    return lvl;
  endfunction

endpackage

// ===== src/ble_div.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator constant divider
// Divides by ten or by the ring depth through a reciprocal multiplication:
// the dividend is registered first, then the product.
// ----------------------------------------------------------------------------
module ble_div #(
  parameter int unsigned DdW   = ble_pkg::PROD_W,
  parameter int unsigned Depth = ble_pkg::RING_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           by_depth_i,
  input  logic [DdW-1:0] dividend_i,
  output logic           busy_o,
  output logic [DdW-1:0] quotient_o
);

  localparam int unsigned MW      = DdW + 1;
  localparam int unsigned PW      = DdW + MW;
  localparam int unsigned ShTen   = DdW + $clog2(ble_pkg::VOLT_DIVISOR);
  localparam int unsigned ShDepth = DdW + $clog2(Depth);

  localparam logic [MW-1:0] MagicTen =
    MW'(((64'd1 << ShTen) + 64'(ble_pkg::VOLT_DIVISOR) - 64'd1) /
        64'(ble_pkg::VOLT_DIVISOR));
  localparam logic [MW-1:0] MagicDepth =
    MW'(((64'd1 << ShDepth) + 64'(Depth) - 64'd1) / 64'(Depth));

  logic           busy_q;
  logic           by_depth_q;
  logic [DdW-1:0] dd_q;
  logic [PW-1:0]  prod_q;
  logic [MW-1:0]  magic;

  assign magic = by_depth_q ? MagicDepth : MagicTen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q       <= dividend_i;
      by_depth_q <= by_depth_i;
    end
    if (busy_q) begin
      prod_q <= PW'(dd_q) * PW'(magic);
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = by_depth_q ? DdW'(prod_q >> ShDepth) : DdW'(prod_q >> ShTen);

endmodule

// ===== src/battery_level_estimator.sv =====
// ----------------------------------------------------------------------------
// Battery level estimator
// Median filter, offset and clamp, sample ring with averaging, and report.
// ----------------------------------------------------------------------------
// Each input transfer carries three ADC samples and the charger source; the
// block takes one transfer at a time and is not ready until it has finished
// with it. An item without a report is only corrected and written to the
// ring. A warm-up item goes through the correction, the product of value
// and scale, and the shared constant divider, which scales by one tenth
// through a reciprocal multiplication. The item that closes the ring reads
// one ring entry per cycle through the single memory read port, then makes
// two passes through the same divider, first for the average and then for
// the voltage. A finished report waits in the output register, and the next
// input may be taken meanwhile; a report that finds the register still full
// holds the block until it drains. The configuration port is always ready.
module battery_level_estimator #(
  parameter int unsigned RingDepth = ble_pkg::RING_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // sample_a, sample_b, sample_c (12 bits each), zero pad
  input  logic [ble_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // charger_source
  input  logic [ble_pkg::SRC_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // reported_voltage (19), level_percent (7), charge_enable (1),
  // charge_status (2), zero pad
  output logic [ble_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ble_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ble_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SW   = ble_pkg::SAMPLE_W;
  localparam int unsigned PosW = $clog2(RingDepth);
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam int unsigned SumW = SW + $clog2(RingDepth);
  localparam int unsigned DdW  = ble_pkg::PROD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORR,
    S_SUM,
    S_AVG,
    S_MUL,
    S_SCL
  } state_e;

  state_e state_q;

  logic [ble_pkg::OFFSET_W-1:0] med_off_q;
  logic [ble_pkg::OFFSET_W-1:0] extra_off_q;
  logic [SW-1:0]                clamp_low_q;
  logic [SW-1:0]                clamp_high_q;
  logic [ble_pkg::SCALE_W-1:0]  scale_q;
  logic [ble_pkg::WARM_W-1:0]   rewarm_q;

  logic [SW-1:0]                a_q;
  logic [SW-1:0]                b_q;
  logic [SW-1:0]                c_q;
  logic [ble_pkg::SRC_W-1:0]    src_q;
  logic [ble_pkg::SRC_W-1:0]    last_src_q;
  logic [ble_pkg::WARM_W-1:0]   warm_q;
  logic [PosW-1:0]              pos_q;
  logic [CntW-1:0]              cnt_q;
  logic [SumW-1:0]              acc_q;
  logic [SW-1:0]                rd_q;
  logic [SW-1:0]                val_q;
  logic                         m_valid_q;
  logic [ble_pkg::VOLT_W-1:0]   volt_q;
  logic [ble_pkg::LEVEL_W-1:0]  lvl_q;
  logic                         en_q;
  logic [ble_pkg::STATUS_W-1:0] st_q;

  logic [SW-1:0] ring [RingDepth];

  logic [SW-1:0]                lo;
  logic [SW-1:0]                hi;
  logic [SW-1:0]                med;
  logic [SW:0]                  corr_sum;
  logic [SW:0]                  after_low;
  logic [SW-1:0]                corr;
  logic                         warm_active;
  logic [ble_pkg::WARM_W-1:0]   warm_dec;
  logic                         pos_last;
  logic [SumW-1:0]              sum_full;
  logic                         sum_done;
  logic [DdW-1:0]               prod;
  logic [ble_pkg::LEVEL_W-1:0]  level;
  logic                         on_ac;
  logic                         out_free;
  logic                         report_fire;
  logic                         ring_we;
  logic                         ring_re;
  logic                         div_start;
  logic [DdW-1:0]               div_dividend;
  logic                         div_by_depth;
  logic                         div_busy;
  logic [DdW-1:0]               div_quo;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_off_q    <= ble_pkg::MEDIAN_OFFSET_RESET;
      extra_off_q  <= ble_pkg::EXTRA_OFFSET_RESET;
      clamp_low_q  <= ble_pkg::CLAMP_LOW_RESET;
      clamp_high_q <= ble_pkg::CLAMP_HIGH_RESET;
      scale_q      <= ble_pkg::SCALE_RESET;
      rewarm_q     <= ble_pkg::REWARM_RESET;
    end else if (cfg_valid_i) begin
      case (ble_pkg::cfg_index_e'(cfg_index_i))
        ble_pkg::CFG_MEDIAN_OFFSET: med_off_q    <= cfg_data_i[ble_pkg::OFFSET_W-1:0];
        ble_pkg::CFG_EXTRA_OFFSET:  extra_off_q  <= cfg_data_i[ble_pkg::OFFSET_W-1:0];
        ble_pkg::CFG_CLAMP_LOW:     clamp_low_q  <= cfg_data_i[SW-1:0];
        ble_pkg::CFG_CLAMP_HIGH:    clamp_high_q <= cfg_data_i[SW-1:0];
        ble_pkg::CFG_VOLT_SCALE:    scale_q      <= cfg_data_i[ble_pkg::SCALE_W-1:0];
        // A write to the warm-up count is ignored; the initial warm-up is set only by reset.
        ble_pkg::CFG_WARMUP_ITEMS:  ;
        ble_pkg::CFG_REWARM_ITEMS:  rewarm_q     <= cfg_data_i[ble_pkg::WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lo        = (a_q < b_q) ? a_q : b_q;
    hi        = (a_q < b_q) ? b_q : a_q;
    med       = (c_q <= lo) ? lo : ((c_q >= hi) ? hi : c_q);
    corr_sum  = {1'b0, med} + (SW + 1)'(med_off_q) +
                ((last_src_q == ble_pkg::SRC_BATTERY) ? (SW + 1)'(extra_off_q) : '0);
    after_low = (corr_sum < {1'b0, clamp_low_q}) ? {1'b0, clamp_low_q} : corr_sum;
    corr      = (after_low > {1'b0, clamp_high_q}) ? clamp_high_q : after_low[SW-1:0];

    warm_active = warm_q != '0;
    warm_dec    = warm_active ? warm_q - ble_pkg::WARM_W'(1) : warm_q;
    pos_last    = pos_q == PosW'(RingDepth - 1);
    sum_full    = acc_q + SumW'(rd_q);
    sum_done    = cnt_q == CntW'(RingDepth);
    prod        = DdW'(val_q) * DdW'(scale_q);

    level       = ble_pkg::band_level(val_q);
    on_ac       = src_q == ble_pkg::SRC_AC;
    out_free    = !m_valid_q || m_axis_tready;
    report_fire = (state_q == S_SCL) && !div_busy && out_free;

    ring_we = state_q == S_CORR;
    ring_re = (state_q == S_SUM) && !sum_done;

    div_start    = 1'b0;
    div_dividend = DdW'(prod);
    div_by_depth = 1'b0;
    if (state_q == S_SUM && sum_done) begin
      div_start    = 1'b1;
      div_dividend = DdW'(sum_full);
      div_by_depth = 1'b1;
    end else if (state_q == S_MUL) begin
      div_start = 1'b1;
    end
  end

  ble_div #(
    .DdW   (DdW),
    .Depth (RingDepth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .by_depth_i (div_by_depth),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[pos_q] <= corr;
    end
    if (ring_re) begin
      rd_q <= ring[cnt_q[PosW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      warm_q     <= ble_pkg::WARMUP_RESET;
      last_src_q <= ble_pkg::SRC_AC;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (report_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            a_q     <= s_axis_tdata[SW-1:0];
            b_q     <= s_axis_tdata[2*SW-1:SW];
            c_q     <= s_axis_tdata[3*SW-1:2*SW];
            src_q   <= s_axis_tuser;
            state_q <= S_CORR;
          end
        end
        S_CORR: begin
          val_q <= corr;
          pos_q <= pos_last ? '0 : pos_q + PosW'(1);
          cnt_q <= '0;
          acc_q <= '0;
          if (src_q != last_src_q) begin
            last_src_q <= src_q;
            warm_q     <= (warm_dec == '0) ? rewarm_q : warm_dec;
          end else begin
            warm_q <= warm_dec;
          end
          if (warm_active) begin
            state_q <= S_MUL;
          end else if (pos_last) begin
            state_q <= S_SUM;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SUM: begin
          if (sum_done) begin
            state_q <= S_AVG;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
            if (cnt_q != '0) begin
              acc_q <= sum_full;
            end
          end
        end
        S_AVG: begin
          if (!div_busy) begin
            val_q   <= div_quo[SW-1:0];
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_SCL;
        end
        S_SCL: begin
          if (report_fire) begin
            volt_q <= div_quo[ble_pkg::VOLT_W-1:0];
            lvl_q  <= level;
            en_q   <= on_ac && (level != ble_pkg::LEVEL_FULL);
            if (!on_ac) begin
              st_q <= ble_pkg::STAT_IDLE;
            end else if (level == ble_pkg::LEVEL_FULL) begin
              st_q <= ble_pkg::STAT_FULL;
            end else begin
              st_q <= ble_pkg::STAT_CHARGING;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, st_q, en_q, lvl_q, volt_q};

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(RingDepth - 1))
    else $error("ring position beyond the last entry");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while still busy");

  a_warm_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORR && warm_active) |=> state_q == S_MUL)
    else $error("warm-up item did not go on to a report");

  a_accept_to_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_CORR && !div_busy))
    else $error("accepted transfer not taken into correction");

endmodule

// ===== sim/battery_level_estimator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator testbench
// Streams sample sets through the estimator under several register settings,
// with random idle cycles on both sides. It predicts every report from its own
// copy of the filter, ring and warm-up state and compares each field.
// ----------------------------------------------------------------------------
module battery_level_estimator_tb;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned GAP_MAX        = 5;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 75;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned SW             = ble_pkg::SAMPLE_W;
  localparam int unsigned SAMPLE_MAX     = (1 << ble_pkg::SAMPLE_W) - 1;
  localparam int unsigned LEVEL_LSB      = ble_pkg::VOLT_W;
  localparam int unsigned ENABLE_BIT     = ble_pkg::VOLT_W + ble_pkg::LEVEL_W;
  localparam int unsigned STATUS_LSB     = ble_pkg::VOLT_W + ble_pkg::LEVEL_W + 1;

  localparam logic [ble_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam logic [ble_pkg::SRC_W-1:0]     SRC_UNKNOWN      = 2'd3;

  typedef struct packed {
    logic [ble_pkg::VOLT_W-1:0]   volt;
    logic [ble_pkg::LEVEL_W-1:0]  level;
    logic                         enable;
    logic [ble_pkg::STATUS_W-1:0] status;
  } report_t;

  typedef struct {
    logic [ble_pkg::CFG_DATA_W-1:0] median_off;
    logic [ble_pkg::CFG_DATA_W-1:0] extra_off;
    logic [ble_pkg::CFG_DATA_W-1:0] clamp_lo;
    logic [ble_pkg::CFG_DATA_W-1:0] clamp_hi;
    logic [ble_pkg::CFG_DATA_W-1:0] scale;
    logic [ble_pkg::CFG_DATA_W-1:0] warmup;
    logic [ble_pkg::CFG_DATA_W-1:0] rewarm;
    logic [ble_pkg::CFG_DATA_W-1:0] spare;
  } reg_set_t;

  class battery_report_board;
    logic [ble_pkg::OFFSET_W-1:0] median_off;
    logic [ble_pkg::OFFSET_W-1:0] extra_off;
    logic [SW-1:0]                clamp_lo;
    logic [SW-1:0]                clamp_hi;
    logic [ble_pkg::SCALE_W-1:0]  scale;
    logic [ble_pkg::WARM_W-1:0]   warmup;
    logic [ble_pkg::WARM_W-1:0]   rewarm;
    logic [SW-1:0]                ring [ble_pkg::RING_DEPTH];
    int unsigned                  ring_pos;
    logic [ble_pkg::WARM_W-1:0]   warm_left;
    logic [ble_pkg::SRC_W-1:0]    prev_src;
    report_t                      pending_reports [$];
    int unsigned                  mismatches;

    function new();
      median_off  = ble_pkg::MEDIAN_OFFSET_RESET;
      extra_off   = ble_pkg::EXTRA_OFFSET_RESET;
      clamp_lo    = ble_pkg::CLAMP_LOW_RESET;
      clamp_hi    = ble_pkg::CLAMP_HIGH_RESET;
      scale       = ble_pkg::SCALE_RESET;
      warmup      = ble_pkg::WARMUP_RESET;
      rewarm      = ble_pkg::REWARM_RESET;
      ring_pos    = 0;
      warm_left   = ble_pkg::WARMUP_RESET;
      prev_src    = ble_pkg::SRC_AC;
      mismatches  = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void write_reg(logic [ble_pkg::CFG_IDX_W-1:0] idx,
                            logic [ble_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ble_pkg::CFG_MEDIAN_OFFSET: median_off = data[ble_pkg::OFFSET_W-1:0];
        ble_pkg::CFG_EXTRA_OFFSET:  extra_off  = data[ble_pkg::OFFSET_W-1:0];
        ble_pkg::CFG_CLAMP_LOW:     clamp_lo   = data[SW-1:0];
        ble_pkg::CFG_CLAMP_HIGH:    clamp_hi   = data[SW-1:0];
        ble_pkg::CFG_VOLT_SCALE:    scale      = data[ble_pkg::SCALE_W-1:0];
        ble_pkg::CFG_WARMUP_ITEMS:  warmup     = data[ble_pkg::WARM_W-1:0];
        ble_pkg::CFG_REWARM_ITEMS:  rewarm     = data[ble_pkg::WARM_W-1:0];
        default: ;
      endcase
    endfunction

    function report_t report_for(int unsigned v, logic [ble_pkg::SRC_W-1:0] src);
      report_t     r;
      int unsigned lvl;
      lvl = 0;
      for (int k = 0; k < ble_pkg::NUM_BANDS; k++) begin
        if (lvl == 0 && v >= ble_pkg::BAND_FLOOR[k]) lvl = ble_pkg::BAND_PCT[k];
      end
      r.volt   = ble_pkg::VOLT_W'((v * scale) / ble_pkg::VOLT_DIVISOR);
      r.level  = ble_pkg::LEVEL_W'(lvl);
      r.enable = (lvl < ble_pkg::LEVEL_FULL) && (src == ble_pkg::SRC_AC);
      if (src != ble_pkg::SRC_AC) begin
        r.status = ble_pkg::STAT_IDLE;
      end else if (lvl == ble_pkg::LEVEL_FULL) begin
        r.status = ble_pkg::STAT_FULL;
      end else begin
        r.status = ble_pkg::STAT_CHARGING;
      end
      return r;
    endfunction

    function void note_sample_set(logic [SW-1:0] a, logic [SW-1:0] b,
                                  logic [SW-1:0] c, logic [ble_pkg::SRC_W-1:0] src);
      int unsigned lo;
      int unsigned hi;
      int unsigned v;
      int unsigned sum;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
        v = lo;
      end else if (c >= hi) begin
        v = hi;
      end else begin
        v = c;
      end
      v = v + median_off;
      if (prev_src == ble_pkg::SRC_BATTERY) v = v + extra_off;
      if (v < clamp_lo) v = clamp_lo;
      if (v > clamp_hi) v = clamp_hi;
      v = v & SAMPLE_MAX;
      ring[ring_pos] = SW'(v);
      if (warm_left != 0) begin
        warm_left = warm_left - 1'b1;
        pending_reports.push_back(report_for(v, src));
      end else if (ring_pos == ble_pkg::RING_DEPTH - 1) begin
        sum = 0;
        foreach (ring[i]) sum = sum + ring[i];
        pending_reports.push_back(report_for(sum / ble_pkg::RING_DEPTH, src));
      end
      ring_pos = (ring_pos + 1) % ble_pkg::RING_DEPTH;
      if (src != prev_src) begin
        prev_src = src;
        if (warm_left == 0) warm_left = rewarm;
      end
    endfunction

    function void check_field(string what, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_report(logic [ble_pkg::OUT_DATA_W-1:0] tdata);
      report_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report expected none, got %h", $time, tdata);
        return;
      end
      want = pending_reports.pop_front();
      check_field("reported_voltage", want.volt, tdata[ble_pkg::VOLT_W-1:0]);
      check_field("level_percent", want.level, tdata[LEVEL_LSB +: ble_pkg::LEVEL_W]);
      check_field("charge_enable", want.enable, tdata[ENABLE_BIT]);
      check_field("charge_status", want.status, tdata[STATUS_LSB +: ble_pkg::STATUS_W]);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ble_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [ble_pkg::SRC_W-1:0]      s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [ble_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data_i;

  battery_level_estimator uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  battery_report_board       board;
  bit                        tx_idle_on;
  bit                        rx_idle_on;
  logic [ble_pkg::SRC_W-1:0] cur_src;
  int unsigned               quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_sample_set(s_axis_tdata[SW-1:0],
                              s_axis_tdata[2*SW-1:SW],
                              s_axis_tdata[3*SW-1:2*SW], s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic logic [SW-1:0] clip_sample(int x);
    if (x < 0) return '0;
    if (x > int'(SAMPLE_MAX)) return SW'(SAMPLE_MAX);
    return SW'(x);
  endfunction

  task automatic send_sample_set(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                 input logic [SW-1:0] c,
                                 input logic [ble_pkg::SRC_W-1:0] src);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ble_pkg::IN_DATA_W - 3*SW){1'b0}}, c, b, a};
    s_axis_tuser  <= src;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Holds the input back until every report is out and the block has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ble_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ble_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!(cfg_valid_i && cfg_ready_o));
  endtask

  task automatic apply_settings(input reg_set_t s);
    wait_idle();
    write_reg(ble_pkg::CFG_MEDIAN_OFFSET, s.median_off);
    write_reg(ble_pkg::CFG_EXTRA_OFFSET, s.extra_off);
    write_reg(ble_pkg::CFG_CLAMP_LOW, s.clamp_lo);
    write_reg(ble_pkg::CFG_CLAMP_HIGH, s.clamp_hi);
    write_reg(ble_pkg::CFG_VOLT_SCALE, s.scale);
    write_reg(ble_pkg::CFG_WARMUP_ITEMS, s.warmup);
    write_reg(ble_pkg::CFG_REWARM_ITEMS, s.rewarm);
    write_reg(CFG_UNUSED_INDEX, s.spare);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    logic [ble_pkg::SRC_W-1:0] src;
    for (int k = 0; k < ble_pkg::NUM_BANDS; k++) begin
      src = ble_pkg::SRC_W'(k % 4);
      case (k % 3)
        0: send_sample_set(ble_pkg::BAND_FLOOR[k], '0, SW'(SAMPLE_MAX), src);
        1: send_sample_set('0, ble_pkg::BAND_FLOOR[k], SW'(SAMPLE_MAX), src);
        default: send_sample_set(SW'(SAMPLE_MAX), '0, ble_pkg::BAND_FLOOR[k], src);
      endcase
    end
    send_sample_set(ble_pkg::BAND_FLOOR[ble_pkg::NUM_BANDS-1] - 1'b1,
                    ble_pkg::BAND_FLOOR[ble_pkg::NUM_BANDS-1] - 1'b1,
                    ble_pkg::BAND_FLOOR[ble_pkg::NUM_BANDS-1] - 1'b1, ble_pkg::SRC_AC);
    send_sample_set(ble_pkg::BAND_FLOOR[0] - 1'b1, SW'(SAMPLE_MAX), '0, ble_pkg::SRC_AC);
    send_sample_set('0, '0, '0, ble_pkg::SRC_BATTERY);
    send_sample_set(SW'(SAMPLE_MAX), SW'(SAMPLE_MAX), SW'(SAMPLE_MAX), ble_pkg::SRC_USB);
    send_sample_set(SW'(SAMPLE_MAX), '0, SW'(SAMPLE_MAX), ble_pkg::SRC_AC);
    send_sample_set(12'd1234, 12'd1234, 12'd2345, SRC_UNKNOWN);
  endtask

  // The source mostly stays put so that warm-up runs out and the ring average
  // gets reported; most samples cluster around the band floors.
  task automatic run_random(input int unsigned n);
    logic [SW-1:0] s [3];
    int            base;
    int unsigned   mode;
    int unsigned   rot;
    int unsigned   k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        cur_src = ($urandom_range(0, 9) == 0) ? SRC_UNKNOWN :
                  ble_pkg::SRC_W'($urandom_range(0, 2));
      end
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        k    = $urandom_range(0, ble_pkg::NUM_BANDS - 1);
        base = int'(ble_pkg::BAND_FLOOR[k]) - int'(board.median_off) +
               int'($urandom_range(0, 2)) - 1;
        if (board.prev_src == ble_pkg::SRC_BATTERY) base = base - int'(board.extra_off);
        rot  = $urandom_range(0, 2);
        s[rot]           = clip_sample(base);
        s[(rot + 1) % 3] = clip_sample(base - int'($urandom_range(0, 40)));
        s[(rot + 2) % 3] = clip_sample(base + int'($urandom_range(0, 40)));
      end else if (mode < 17) begin
        foreach (s[j]) s[j] = SW'($urandom_range(0, SAMPLE_MAX));
      end else begin
        foreach (s[j]) s[j] = $urandom_range(0, 1) ? SW'(SAMPLE_MAX) : '0;
      end
      send_sample_set(s[0], s[1], s[2], cur_src);
    end
  endtask

  function automatic reg_set_t random_settings();
    reg_set_t s;
    s.median_off = ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
    s.extra_off  = ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
    s.clamp_lo   = ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
    s.clamp_hi   = ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
    s.scale      = ble_pkg::CFG_DATA_W'($urandom_range(1, 1000));
    s.warmup     = ble_pkg::CFG_DATA_W'($urandom_range(0, 255));
    s.rewarm     = ble_pkg::CFG_DATA_W'($urandom_range(0, 255));
    s.spare      = ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
    return s;
  endfunction

  initial begin
    reg_set_t settings;
    board         = new();
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ble_pkg::SRC_AC;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= ble_pkg::CFG_MEDIAN_OFFSET;
    cfg_data_i    <= '0;
    quiet_cycles  <= 0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    cur_src       = ble_pkg::SRC_AC;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Offsets off and clamps wide open, so that each report shows the median.
    settings = '{12'd0, 12'd0, 12'd0, 12'hFFF, 12'd100, 12'd30, 12'd3,
                 ble_pkg::CFG_DATA_W'($urandom_range(0, SAMPLE_MAX))};
    apply_settings(settings);
    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: settings = '{12'd10, 12'd10, 12'd250, 12'd450, 12'd100, 12'd30, 12'd3, 12'd0};
        1: settings = '{12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
        2: settings = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
        3: settings = '{12'd10, 12'd10, 12'd400, 12'd300, 12'd1, 12'd0, 12'd1, 12'h5A5};
        6: settings = '{12'd5, 12'd20, 12'd300, 12'd440, 12'd1000, 12'd0, 12'd0, 12'hA5A};
        default: settings = random_settings();
      endcase
      tx_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
      apply_settings(settings);
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ble_pkg.sv
src/ble_div.sv
src/battery_level_estimator.sv
sim/battery_level_estimator_tb.sv
